FILE: design/scp_pkg.sv
`default_nettype none

package scp_pkg;

	// operation codes of the input beat
	localparam logic [1:0] OP_WRITE_OBJ    = 2'd0;
	localparam logic [1:0] OP_WRITE_PLAYER = 2'd1;
	localparam logic [1:0] OP_SET_RADII    = 2'd2;
	localparam logic [1:0] OP_SCAN         = 2'd3;

	// register file
	localparam int          APB_ADDR_W       = 3;
	localparam logic        REG_OBJECT_COUNT = 1'b0;
	localparam int          OBJ_CNT_W        = 7;

	// input beat
	typedef struct packed {
		logic [1:0]         operation;
		logic [5:0]         object_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0]        radius;
		logic               radius_valid;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic [5:0]         hit_index;
		logic signed [31:0] push_x;
		logic signed [31:0] push_y;
		logic signed [31:0] moved_x;
		logic signed [31:0] moved_y;
		logic signed [31:0] object_z;
		logic               last;
	} hit_t;

	// classified job handed from front to back
	typedef enum logic [1:0] {
		KIND_OBJ    = 2'd0,
		KIND_PLAYER = 2'd1,
		KIND_RADII  = 2'd2,
		KIND_SCAN   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [5:0]         index;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        radius;
		logic               radius_valid;
	} job_t;

	typedef struct packed {
		logic [1:0] count;
	} front_stat_t;

	typedef struct packed {
		logic idle;
		logic pend_vld;
	} back_stat_t;

endpackage

`default_nettype wire

FILE: design/scp_front.sv
`default_nettype none

module scp_front #(
	parameter int MAX_OBJECTS = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_ready,
	input  scp_pkg::cmd_t       cmd,
	output logic                job_valid,
	input  wire                 job_ready,
	output scp_pkg::job_t       job,
	output scp_pkg::front_stat_t stat
);

	scp_pkg::job_t q_mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	scp_pkg::job_t cls;
	logic          keep;
	logic          push;
	logic          pop;

	// classify the beat, drop object writes outside the table
	always_comb begin
		cls.index        = cmd.object_index;
		cls.x            = cmd.pos_x;
		cls.y            = cmd.pos_y;
		cls.z            = cmd.pos_z;
		cls.radius       = cmd.radius;
		cls.radius_valid = cmd.radius_valid;
		keep             = 1'b1;
		case (cmd.operation)
			scp_pkg::OP_WRITE_OBJ: begin
				cls.kind = scp_pkg::KIND_OBJ;
				keep     = (32'(cmd.object_index) < 32'(MAX_OBJECTS));
			end
			scp_pkg::OP_WRITE_PLAYER: cls.kind = scp_pkg::KIND_PLAYER;
			scp_pkg::OP_SET_RADII:    cls.kind = scp_pkg::KIND_RADII;
			default:                  cls.kind = scp_pkg::KIND_SCAN;
		endcase
	end

	assign cmd_ready = (cnt_q != 2'd2);
	assign push      = cmd_valid && cmd_ready && keep;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job       = q_mem_q[rd_ptr_q];
	assign stat.count = cnt_q;

	// two entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

FILE: design/scp_sqrt.sv
`default_nettype none

module scp_sqrt (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] rem_next;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	// one result bit per cycle, restoring form
	assign rem_next = {rem_q, rad_q[63:62]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign ge       = (rem_next >= trial);
	assign diff     = rem_next - trial;
	assign done     = done_q;
	assign root     = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 5'd0;
			end else if (run_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? diff[33:0] : rem_next[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

endmodule

`default_nettype wire

FILE: design/scp_div.sv
`default_nettype none

module scp_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] dividend,
	input  wire  [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] lq_q;
	logic [31:0] div_q;
	logic [4:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] rem2;
	logic [32:0] diff;
	logic        ge;

	// one quotient bit per cycle, upper half of the dividend is below the divisor
	assign rem2     = {rem_q, lq_q[31]};
	assign ge       = (rem2 >= {1'b0, div_q});
	assign diff     = rem2 - {1'b0, div_q};
	assign done     = done_q;
	assign quotient = lq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 5'd0;
			end else if (run_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			lq_q  <= dividend[31:0];
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : rem2[31:0];
			lq_q  <= {lq_q[30:0], ge};
		end
	end

endmodule

`default_nettype wire

FILE: design/scp_back.sv
`default_nettype none

module scp_back #(
	parameter int MAX_OBJECTS = 64,
	parameter int FRAC_BITS   = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       job_valid,
	output logic                      job_ready,
	input  scp_pkg::job_t             job,
	input  wire [scp_pkg::OBJ_CNT_W-1:0] object_count,
	output logic                      hit_valid,
	input  wire                       hit_ready,
	output scp_pkg::hit_t             hit,
	output scp_pkg::back_stat_t       stat
);

	localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
	localparam logic [30:0] RAD_ONE = 31'(64'd1 << FRAC_BITS);

	typedef enum logic [24:0] {
		ST_IDLE  = 25'h0000001,
		ST_SWEEP = 25'h0000002,
		ST_RD    = 25'h0000004,
		ST_LAT   = 25'h0000008,
		ST_MX    = 25'h0000010,
		ST_MY    = 25'h0000020,
		ST_MZ    = 25'h0000040,
		ST_MR    = 25'h0000080,
		ST_CHK   = 25'h0000100,
		ST_SQ1   = 25'h0000200,
		ST_NORM  = 25'h0000400,
		ST_MHX   = 25'h0000800,
		ST_MHY   = 25'h0001000,
		ST_HADD  = 25'h0002000,
		ST_SQ2   = 25'h0004000,
		ST_MPX   = 25'h0008000,
		ST_DX0   = 25'h0010000,
		ST_DX    = 25'h0020000,
		ST_MPY   = 25'h0040000,
		ST_DY0   = 25'h0080000,
		ST_DY    = 25'h0100000,
		ST_SAT   = 25'h0200000,
		ST_MOV   = 25'h0400000,
		ST_EMIT  = 25'h0800000,
		ST_FLUSH = 25'h1000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  scan_n;
	logic [30:0]       sweep_rad_q;
	logic signed [31:0] plx_q, ply_q, plz_q;
	logic [30:0]       plr_q;

	// object table
	logic [95:0]       pos_mem [MAX_OBJECTS];
	logic [30:0]       rad_mem [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0] pos_vld_q;
	logic [MAX_OBJECTS-1:0] rad_vld_q;
	logic [95:0]       rd_pos_q;
	logic [30:0]       rd_rad_q;
	logic              rd_pvld_q;
	logic              rd_rvld_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  job_addr;
	logic              pos_we;
	logic              rad_we;
	logic [IDX_W-1:0]  rad_wa;
	logic [30:0]       rad_wd;

	// per entry datapath
	logic signed [31:0] tx_q, ty_q, tz_q;
	logic [32:0]       ax_q, ay_q, az_q;
	logic              sx_q, sy_q;
	logic [31:0]       radii_q;
	logic [63:0]       mul_q;
	logic [31:0]       mul_a, mul_b;
	logic [65:0]       sum_q;
	logic [31:0]       m_q;
	logic [31:0]       hx_q, hy_q, amax_q;
	logic [31:0]       h_q;
	logic [31:0]       pxm_q, pym_q;
	logic signed [31:0] pushx_q, pushy_q;
	scp_pkg::hit_t     res_q;
	scp_pkg::hit_t     pend_q;
	logic              pend_vld_q;
	scp_pkg::hit_t     out_q;
	logic              out_vld_q;
	logic              slot_free;
	logic              out_load;

	logic signed [31:0] tx_rd, ty_rd, tz_rd;
	logic [30:0]       ro_rd;
	logic signed [32:0] dx, dy, dz;
	logic [32:0]       amax_n;
	logic [31:0]       m_new;
	logic [4:0]        nsh;
	logic              reject;
	logic              in_hit;
	logic              coincident;

	logic              sq_start, sq_done;
	logic [63:0]       sq_in;
	logic [31:0]       sq_root;
	logic              dv_start, dv_done;
	logic [31:0]       dv_quo;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			sat33 = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			sat33 = v[31:0];
		end
	endfunction

	function automatic logic signed [31:0] sat_push(input logic [31:0] mg, input logic neg);
		if (neg) begin
			sat_push = mg[31] ? 32'sh80000000 : 32'(-mg);
		end else begin
			sat_push = mg[31] ? 32'sh7FFFFFFF : mg;
		end
	endfunction

	// scan length clamped to the table
	assign scan_n = (32'(object_count) > 32'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS)
	                                                       : CNT_W'(object_count);

	assign job_ready = (state_q == ST_IDLE);
	assign slot_free = !out_vld_q || hit_ready;
	assign out_load  = pend_vld_q && slot_free &&
	                   ((state_q == ST_EMIT) || (state_q == ST_FLUSH));
	assign hit_valid = out_vld_q;
	assign hit       = out_q;
	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.pend_vld = pend_vld_q;

	// table write and read ports
	assign rd_addr  = i_q[IDX_W-1:0];
	assign job_addr = IDX_W'(job.index);
	assign pos_we   = (state_q == ST_IDLE) && job_valid && (job.kind == scp_pkg::KIND_OBJ);
	assign rad_we   = (state_q == ST_SWEEP) || (pos_we && job.radius_valid);
	assign rad_wa   = (state_q == ST_SWEEP) ? rd_addr : job_addr;
	assign rad_wd   = (state_q == ST_SWEEP) ? sweep_rad_q : job.radius;

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[job_addr] <= {job.x, job.y, job.z};
		end
		if (rad_we) begin
			rad_mem[rad_wa] <= rad_wd;
		end
		rd_pos_q  <= pos_mem[rd_addr];
		rd_rad_q  <= rad_mem[rd_addr];
		rd_pvld_q <= pos_vld_q[rd_addr];
		rd_rvld_q <= rad_vld_q[rd_addr];
	end

	// entries never written read as their reset value
	assign tx_rd = rd_pvld_q ? rd_pos_q[95:64] : 32'sd0;
	assign ty_rd = rd_pvld_q ? rd_pos_q[63:32] : 32'sd0;
	assign tz_rd = rd_pvld_q ? rd_pos_q[31:0]  : 32'sd0;
	assign ro_rd = rd_rvld_q ? rd_rad_q : RAD_ONE;
	assign dx    = {plx_q[31], plx_q} - {tx_rd[31], tx_rd};
	assign dy    = {ply_q[31], ply_q} - {ty_rd[31], ty_rd};
	assign dz    = {plz_q[31], plz_q} - {tz_rd[31], tz_rd};

	// hit tests
	assign reject = (ax_q >= {1'b0, radii_q}) || (ay_q >= {1'b0, radii_q}) ||
	                (az_q >= {1'b0, radii_q});
	assign in_hit = (sum_q < {2'b00, mul_q});
	assign coincident = (ax_q == 33'd0) && (ay_q == 33'd0);
	assign amax_n = (ax_q > ay_q) ? ax_q : ay_q;
	assign m_new  = radii_q - sq_root;

	// normalise shift, largest step that keeps the magnitude below 2^31
	always_comb begin
		if (amax_q[31:15] == 17'd0) begin
			nsh = 5'd16;
		end else if (amax_q[31:23] == 9'd0) begin
			nsh = 5'd8;
		end else if (amax_q[31:27] == 5'd0) begin
			nsh = 5'd4;
		end else if (amax_q[31:29] == 3'd0) begin
			nsh = 5'd2;
		end else begin
			nsh = 5'd1;
		end
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			ST_MX:   begin mul_a = ax_q[31:0]; mul_b = ax_q[31:0]; end
			ST_MY:   begin mul_a = ay_q[31:0]; mul_b = ay_q[31:0]; end
			ST_MZ:   begin mul_a = az_q[31:0]; mul_b = az_q[31:0]; end
			ST_MR:   begin mul_a = radii_q;    mul_b = radii_q;    end
			ST_MHX:  begin mul_a = hx_q;       mul_b = hx_q;       end
			ST_MHY:  begin mul_a = hy_q;       mul_b = hy_q;       end
			ST_MPX:  begin mul_a = m_q;        mul_b = hx_q;       end
			ST_MPY:  begin mul_a = m_q;        mul_b = hy_q;       end
			default: begin mul_a = 32'd0;      mul_b = 32'd0;      end
		endcase
	end

	// square root and divider hand-off
	assign sq_start = ((state_q == ST_CHK) && in_hit) || (state_q == ST_HADD);
	assign sq_in    = (state_q == ST_HADD) ? (sum_q[63:0] + mul_q) : sum_q[63:0];
	assign dv_start = (state_q == ST_DX0) || (state_q == ST_DY0);

	scp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root)
	);

	scp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (mul_q),
		.divisor  (h_q),
		.done     (dv_done),
		.quotient (dv_quo)
	);

	// sequencer, player registers, valid bits and result slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			n_q        <= '0;
			plx_q      <= '0;
			ply_q      <= '0;
			plz_q      <= '0;
			plr_q      <= RAD_ONE;
			pos_vld_q  <= '0;
			rad_vld_q  <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (hit_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						case (job.kind)
							scp_pkg::KIND_OBJ: begin
								pos_vld_q[job_addr] <= 1'b1;
								if (job.radius_valid) begin
									rad_vld_q[job_addr] <= 1'b1;
								end
							end
							scp_pkg::KIND_PLAYER: begin
								plx_q <= job.x;
								ply_q <= job.y;
								plz_q <= job.z;
								if (job.radius_valid) begin
									plr_q <= job.radius;
								end
							end
							scp_pkg::KIND_RADII: begin
								n_q <= scan_n;
								i_q <= '0;
								if (scan_n != '0) begin
									state_q <= ST_SWEEP;
								end
							end
							default: begin
								n_q     <= scan_n;
								i_q     <= '0;
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					rad_vld_q[rd_addr] <= 1'b1;
					i_q <= i_q + CNT_W'(1);
					if (i_q + CNT_W'(1) == n_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD:   state_q <= (i_q == n_q) ? ST_FLUSH : ST_LAT;
				ST_LAT:  state_q <= ST_MX;
				ST_MX: begin
					if (reject) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_MY;
					end
				end
				ST_MY:   state_q <= ST_MZ;
				ST_MZ:   state_q <= ST_MR;
				ST_MR:   state_q <= ST_CHK;
				ST_CHK: begin
					if (in_hit) begin
						state_q <= ST_SQ1;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_SQ1: begin
					if (sq_done) begin
						if (coincident) begin
							state_q <= ST_SAT;
						end else if (amax_n[31]) begin
							state_q <= ST_MHX;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (amax_q[30]) begin
						state_q <= ST_MHX;
					end
				end
				ST_MHX:  state_q <= ST_MHY;
				ST_MHY:  state_q <= ST_HADD;
				ST_HADD: state_q <= ST_SQ2;
				ST_SQ2: begin
					if (sq_done) begin
						state_q <= ST_MPX;
					end
				end
				ST_MPX:  state_q <= ST_DX0;
				ST_DX0:  state_q <= ST_DX;
				ST_DX: begin
					if (dv_done) begin
						state_q <= ST_MPY;
					end
				end
				ST_MPY:  state_q <= ST_DY0;
				ST_DY0:  state_q <= ST_DY;
				ST_DY: begin
					if (dv_done) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT:  state_q <= ST_MOV;
				ST_MOV:  state_q <= ST_EMIT;
				ST_EMIT: begin
					// hold one hit back so the final one can carry last
					if (!pend_vld_q) begin
						pend_vld_q <= 1'b1;
						i_q        <= i_q + CNT_W'(1);
						state_q    <= ST_RD;
					end else if (slot_free) begin
						i_q       <= i_q + CNT_W'(1);
						state_q   <= ST_RD;
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					sweep_rad_q <= job.radius;
				end
			end
			ST_LAT: begin
				tx_q    <= tx_rd;
				ty_q    <= ty_rd;
				tz_q    <= tz_rd;
				sx_q    <= dx[32];
				sy_q    <= dy[32];
				ax_q    <= dx[32] ? 33'(-dx) : 33'(dx);
				ay_q    <= dy[32] ? 33'(-dy) : 33'(dy);
				az_q    <= dz[32] ? 33'(-dz) : 33'(dz);
				radii_q <= {1'b0, plr_q} + {1'b0, ro_rd};
			end
			ST_MY:        sum_q <= {2'b00, mul_q};
			ST_MZ, ST_MR: sum_q <= sum_q + {2'b00, mul_q};
			ST_MHY:       sum_q <= {2'b00, mul_q};
			ST_SQ1: begin
				if (sq_done) begin
					m_q <= m_new;
					if (coincident) begin
						pxm_q <= m_new;
						pym_q <= 32'd0;
					end else if (amax_n[31]) begin
						hx_q   <= ax_q[32:1];
						hy_q   <= ay_q[32:1];
						amax_q <= amax_n[32:1];
					end else begin
						hx_q   <= ax_q[31:0];
						hy_q   <= ay_q[31:0];
						amax_q <= amax_n[31:0];
					end
				end
			end
			ST_NORM: begin
				if (!amax_q[30]) begin
					hx_q   <= hx_q << nsh;
					hy_q   <= hy_q << nsh;
					amax_q <= amax_q << nsh;
				end
			end
			ST_SQ2: begin
				if (sq_done) begin
					h_q <= (sq_root == 32'd0) ? 32'd1 : sq_root;
				end
			end
			ST_DX: begin
				if (dv_done) begin
					pxm_q <= dv_quo;
				end
			end
			ST_DY: begin
				if (dv_done) begin
					pym_q <= dv_quo;
				end
			end
			ST_SAT: begin
				pushx_q <= sat_push(pxm_q, sx_q);
				pushy_q <= sat_push(pym_q, sy_q);
			end
			ST_MOV: begin
				res_q.hit_index <= 6'(i_q);
				res_q.push_x    <= pushx_q;
				res_q.push_y    <= pushy_q;
				res_q.moved_x   <= sat33({tx_q[31], tx_q} - {pushx_q[31], pushx_q});
				res_q.moved_y   <= sat33({ty_q[31], ty_q} - {pushy_q[31], pushy_q});
				res_q.object_z  <= tz_q;
				res_q.last      <= 1'b0;
			end
			ST_EMIT: begin
				if (!pend_vld_q) begin
					pend_q <= res_q;
				end else if (slot_free) begin
					out_q  <= pend_q;
					pend_q <= res_q;
				end
			end
			ST_FLUSH: begin
				// last is the lowest bit of the beat
				if (pend_vld_q && slot_free) begin
					out_q <= {pend_q[$bits(scp_pkg::hit_t)-1:1], 1'b1};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/sphere_collision_push_scan.sv
// sphere collision scan with xy push
//
// cmd channel (cmd_valid/cmd_ready/cmd): one beat per operation. object and
// player writes and radius broadcasts only update state; a scan walks the
// first object_count entries of the table and sends one beat on the hit
// channel (hit_valid/hit_ready/hit) for every colliding object, in index
// order, with last set on the final one. a scan without hits sends nothing.
// object_count must be written over the apb port only while the block is idle;
// the block does not enforce this. cmd beats go into a two entry queue, so the
// sender is held whenever the queue is full.
// back end: a write only updates state; a radius broadcast writes the radius of
// each of the first object_count objects in turn. a scan drops a missed object
// by the per-axis bound test or by the squared-distance test. a hit uses the
// bit-serial square root twice and the bit-serial divider twice, or only the root
// once when dx and dy are both zero. a hit beat appears once the next hit or the
// end of the scan is known.
// a stalled receiver holds the output register; the scan waits on it.
// reset clears the queue, the player (radius 1.0), object_count and the
// table's valid bits, so every object reads as zero with radius 1.0.

`default_nettype none

module sphere_collision_push_scan #(
	parameter int MAX_OBJECTS = 64,
	parameter int FRAC_BITS   = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmd_valid,
	output logic                             cmd_ready,
	input  scp_pkg::cmd_t                    cmd,
	output logic                             hit_valid,
	input  wire                              hit_ready,
	output scp_pkg::hit_t                    hit,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [scp_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [scp_pkg::OBJ_CNT_W-1:0] obj_cnt_q;
	logic                          job_valid;
	logic                          job_ready;
	scp_pkg::job_t                 job;
	scp_pkg::front_stat_t          front_stat;
	scp_pkg::back_stat_t           back_stat;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[scp_pkg::APB_ADDR_W-1] == scp_pkg::REG_OBJECT_COUNT) ?
	                {{(32 - scp_pkg::OBJ_CNT_W){1'b0}}, obj_cnt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_cnt_q <= '0;
		end else if (psel && penable && pwrite && pready &&
		             paddr[scp_pkg::APB_ADDR_W-1] == scp_pkg::REG_OBJECT_COUNT) begin
			obj_cnt_q <= pwdata[scp_pkg::OBJ_CNT_W-1:0];
		end
	end

	scp_front #(
		.MAX_OBJECTS (MAX_OBJECTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.stat      (front_stat)
	);

	scp_back #(
		.MAX_OBJECTS (MAX_OBJECTS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (job),
		.object_count (obj_cnt_q),
		.hit_valid    (hit_valid),
		.hit_ready    (hit_ready),
		.hit          (hit),
		.stat         (back_stat)
	);

	// queue never holds more than its two entries
	a_queue_depth: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.count != 2'd3)
		else $error("command queue overfilled");

	// a held-back hit never survives the end of a scan
	a_no_stale_hit: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.idle |-> !back_stat.pend_vld)
		else $error("pending hit left after scan");

	// reported index lies inside the table
	a_hit_index: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid |-> (32'(hit.hit_index) < 32'(MAX_OBJECTS)))
		else $error("hit index outside table");

endmodule

`default_nettype wire

FILE: test/tb_sphere_collision_push_scan.sv
`default_nettype none

module tb_sphere_collision_push_scan;
	timeunit 1ns;
	timeprecision 1ps;

	// predicts hit beats of each scan and checks them in order
	class collision_scoreboard;
		longint          obj_x[64], obj_y[64], obj_z[64];
		longint unsigned obj_rad[64];
		longint          ply_x, ply_y, ply_z;
		longint unsigned ply_rad;
		int unsigned     obj_count;
		scp_pkg::hit_t   pending_hits[$];
		int              mismatches;

		function new();
			for (int i = 0; i < 64; i++) begin
				obj_x[i] = 0; obj_y[i] = 0; obj_z[i] = 0;
				obj_rad[i] = 64'd1 << 16;
			end
			ply_x = 0; ply_y = 0; ply_z = 0;
			ply_rad = 64'd1 << 16;
			obj_count = 0;
			mismatches = 0;
		endfunction

		function void set_count(int unsigned v);
			obj_count = v & 7'h7f;
		endfunction

		function int pending();
			return pending_hits.size();
		endfunction

		function longint unsigned root(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint unsigned absval(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		// walk the table as a scan does
		function void predict_scan();
			int unsigned n;
			scp_pkg::hit_t h;
			int hits;
			longint dx, dy, dz, pushx, pushy;
			longint unsigned ax, ay, az, radii, lim, sum, m, pxm, pym, hx, hy, a, hh;
			hits = 0;
			n = (obj_count > 64) ? 64 : obj_count;
			for (int i = 0; i < n; i++) begin
				dx = ply_x - obj_x[i];
				dy = ply_y - obj_y[i];
				dz = ply_z - obj_z[i];
				ax = absval(dx); ay = absval(dy); az = absval(dz);
				radii = ply_rad + obj_rad[i];
				if (ax >= radii || ay >= radii || az >= radii) continue;
				lim = radii * radii;
				sum = ax * ax;
				if (sum >= lim || ay * ay >= lim - sum) continue;
				sum += ay * ay;
				if (az * az >= lim - sum) continue;
				sum += az * az;
				m = radii - root(sum);
				// coincident xy pushes along x
				if (ax == 0 && ay == 0) begin
					pxm = m; pym = 0;
				end else begin
					hx = ax; hy = ay;
					a = (ax > ay) ? ax : ay;
					if (a >= 64'h8000_0000) begin
						hx >>= 1; hy >>= 1;
					end else begin
						while (a < 64'h4000_0000) begin
							a <<= 1; hx <<= 1; hy <<= 1;
						end
					end
					hh = root(hx * hx + hy * hy);
					if (hh == 0) hh = 1;
					pxm = m * hx / hh;
					pym = m * hy / hh;
				end
				if (pxm > 64'h1_0000_0000) pxm = 64'h1_0000_0000;
				if (pym > 64'h1_0000_0000) pym = 64'h1_0000_0000;
				pushx = clip32(dx < 0 ? -longint'(pxm) : longint'(pxm));
				pushy = clip32(dy < 0 ? -longint'(pym) : longint'(pym));
				h.hit_index = i[5:0];
				h.push_x    = pushx[31:0];
				h.push_y    = pushy[31:0];
				h.moved_x   = 32'(clip32(obj_x[i] - pushx));
				h.moved_y   = 32'(clip32(obj_y[i] - pushy));
				h.object_z  = obj_z[i][31:0];
				h.last      = 1'b0;
				pending_hits.push_back(h);
				hits++;
			end
			if (hits > 0) pending_hits[pending_hits.size() - 1].last = 1'b1;
		endfunction

		function void note_cmd(scp_pkg::cmd_t c);
			case (c.operation)
				scp_pkg::OP_WRITE_OBJ: begin
					obj_x[c.object_index] = c.pos_x;
					obj_y[c.object_index] = c.pos_y;
					obj_z[c.object_index] = c.pos_z;
					if (c.radius_valid) obj_rad[c.object_index] = c.radius;
				end
				scp_pkg::OP_WRITE_PLAYER: begin
					ply_x = c.pos_x; ply_y = c.pos_y; ply_z = c.pos_z;
					if (c.radius_valid) ply_rad = c.radius;
				end
				scp_pkg::OP_SET_RADII: begin
					for (int i = 0; i < ((obj_count > 64) ? 64 : obj_count); i++)
						obj_rad[i] = c.radius;
				end
				default: predict_scan();
			endcase
		endfunction

		function void check_hit(scp_pkg::hit_t h);
			scp_pkg::hit_t e;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected hit beat %p", h);
				return;
			end
			e = pending_hits.pop_front();
			if (h.hit_index !== e.hit_index || h.push_x !== e.push_x ||
			    h.push_y !== e.push_y || h.moved_x !== e.moved_x ||
			    h.moved_y !== e.moved_y || h.object_z !== e.object_z ||
			    h.last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("hit mismatch: expected %p actual %p", e, h);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cmd_valid;
	logic                           cmd_ready;
	scp_pkg::cmd_t                  cmd;
	logic                           hit_valid;
	logic                           hit_ready;
	scp_pkg::hit_t                  hit;
	logic                           psel, penable, pwrite;
	logic [scp_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;

	collision_scoreboard sb;
	bit quiet;

	sphere_collision_push_scan DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.hit_valid(hit_valid), .hit_ready(hit_ready), .hit(hit),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function int gap_draw();
		return quiet ? 0 : $urandom_range(0, 5);
	endfunction

	// beats seen on both channels
	always @(posedge clk) begin
		if (arst_n && cmd_valid && cmd_ready) sb.note_cmd(cmd);
		if (arst_n && hit_valid && hit_ready) sb.check_hit(hit);
	end

	// receiver with random back-pressure
	initial begin
		int stall;
		hit_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = gap_draw();
			if (stall > 0) begin
				hit_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hit_ready <= 1'b1;
			do @(posedge clk); while (!(hit_valid && hit_ready));
		end
	end

	task automatic send(scp_pkg::cmd_t c);
		int g;
		g = gap_draw();
		if (g > 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic beat(logic [1:0] op, int idx, int x, int y, int z, int r, bit rv);
		scp_pkg::cmd_t c;
		c.operation    = op;
		c.object_index = idx[5:0];
		c.pos_x        = x;
		c.pos_y        = y;
		c.pos_z        = z;
		c.radius       = r[30:0];
		c.radius_valid = rv;
		send(c);
	endtask

	// drain, let the back end settle, then write object_count
	task automatic set_object_count(int unsigned v);
		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4000) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= scp_pkg::APB_ADDR_W'(4 * int'(scp_pkg::REG_OBJECT_COUNT));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_count(v);
		quiet = ~quiet;
	endtask

	task automatic random_phase(int items);
		int cx, cy, cz, rad, dd;
		cx = $urandom; cy = $urandom; cz = $urandom;
		rad = $urandom_range(1, 1 << 18);
		for (int k = 0; k < items; k++) begin
			dd = 2 * rad;
			case ($urandom_range(0, 9))
				0: beat(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
					1'($urandom));
				1: beat(scp_pkg::OP_WRITE_PLAYER, $urandom, cx + $urandom_range(0, 2 * dd) - dd,
					cy + $urandom_range(0, 2 * dd) - dd, cz + $urandom_range(0, dd) - dd / 2,
					$urandom_range(0, 2 * rad), 1'($urandom));
				2: beat(scp_pkg::OP_SET_RADII, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 2 * rad), 1'($urandom));
				3, 4: beat(scp_pkg::OP_SCAN, $urandom, $urandom, $urandom, $urandom, $urandom,
					1'($urandom));
				default: beat(scp_pkg::OP_WRITE_OBJ, $urandom_range(0, 63),
					cx + $urandom_range(0, 2 * dd) - dd, cy + $urandom_range(0, 2 * dd) - dd,
					cz + $urandom_range(0, dd) - dd / 2, $urandom_range(0, 2 * rad),
					1'($urandom));
			endcase
		end
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		paddr <= '0; pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing scanned while object_count is zero
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
		beat(scp_pkg::OP_SET_RADII, 0, 0, 0, 0, 5, 0);
		beat(scp_pkg::OP_WRITE_OBJ, 63, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 1);
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);

		// coincident xy, plain hits, misses
		set_object_count(4);
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
		beat(scp_pkg::OP_WRITE_OBJ, 1, 32'h8000, -32'h4000, 32'h1000, 32'h20000, 1);
		beat(scp_pkg::OP_WRITE_OBJ, 2, 32'h30000, 0, 0, 0, 0);
		beat(scp_pkg::OP_WRITE_OBJ, 3, 0, 0, 32'h10000, 0, 1);
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);

		// zero radius sum never hits
		beat(scp_pkg::OP_WRITE_PLAYER, 0, 0, 0, 0, 0, 1);
		beat(scp_pkg::OP_SET_RADII, 0, 0, 0, 0, 0, 0);
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);

		// widest radii and coordinates, saturating push and move
		set_object_count(64);
		beat(scp_pkg::OP_WRITE_PLAYER, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff, 1);
		beat(scp_pkg::OP_SET_RADII, 0, 0, 0, 0, 32'h7fffffff, 0);
		beat(scp_pkg::OP_WRITE_OBJ, 5, 32'h80000001, 32'h7fffffff, 0, 32'h7fffffff, 0);
		beat(scp_pkg::OP_WRITE_OBJ, 6, -32'h40000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 1);
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
		beat(scp_pkg::OP_WRITE_PLAYER, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
		beat(scp_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);

		// count above the table acts as the table size
		set_object_count(127);
		random_phase(25);
		set_object_count($urandom_range(1, 63));
		random_phase(25);
		set_object_count(64);
		random_phase(25);
		set_object_count($urandom_range(1, 8));
		random_phase(25);

		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
